// ===== hdl/skvt_pkg.sv =====
package skvt_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;       // latch key/value, open search window
    logic    clear;      // empty the table
    logic    srch_rd;    // read key at midpoint
    logic    srch_cmp;   // narrow window from midpoint key
    logic    probe;      // read entry at lower bound
    logic    up_init;    // cursor to count for insert shift
    logic    up_step;    // move one entry up
    logic    ins_wr;     // write new pair at lower bound
    logic    dn_init;    // cursor to lower bound for remove shift
    logic    dn_step;    // move one entry down
    logic    cnt_inc;
    logic    cnt_dec;
    logic    fin;        // load result word
    status_t fin_status;
    logic    fin_value;  // return stored data
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic hit;
    logic full;
    logic up_end;
    logic dn_end;
  } dp_stat_t;

endpackage

// ===== hdl/skvt_ctrl.sv =====
module skvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  skvt_pkg::cmd_t    command,
  input  skvt_pkg::dp_stat_t stat,
  output skvt_pkg::dp_cmd_t  ctl,
  output logic              busy,
  output logic              done
);
  import skvt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_RD  = 8'b0000_0010,
    S_SRCH_CMP = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_SHUP     = 8'b0001_0000,
    S_INS_WR   = 8'b0010_0000,
    S_SHDN     = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  cmd_t   cmd_r;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.fin_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          if (command == CMD_CLEAR) begin
            ctl.clear = 1'b1;
            ctl.fin   = 1'b1;
          end else begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (stat.srch_done) begin
          ctl.probe  = 1'b1;
          state_next = S_CHECK;
        end else begin
          ctl.srch_rd = 1'b1;
          state_next  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        ctl.srch_cmp = 1'b1;
        state_next   = S_SRCH_RD;
      end
      S_CHECK: begin
        state_next = S_IDLE;
        unique case (cmd_r)
          CMD_LOOKUP: begin
            ctl.fin        = 1'b1;
            ctl.fin_value  = stat.hit;
            ctl.fin_status = stat.hit ? ST_OK : ST_NOT_FOUND;
          end
          CMD_INSERT: begin
            if (stat.hit) begin
              ctl.fin        = 1'b1;
              ctl.fin_status = ST_PRESENT;
            end else if (stat.full) begin
              ctl.fin        = 1'b1;
              ctl.fin_status = ST_FULL;
            end else begin
              ctl.up_init = 1'b1;
              state_next  = S_SHUP;
            end
          end
          CMD_REMOVE: begin
            if (!stat.hit) begin
              ctl.fin        = 1'b1;
              ctl.fin_status = ST_NOT_FOUND;
            end else begin
              ctl.dn_init = 1'b1;
              state_next  = S_SHDN;
            end
          end
          default: begin
            ctl.fin = 1'b1;
          end
        endcase
      end
      S_SHUP: begin
        // last pending move lands this cycle when the cursor meets the slot
        if (stat.up_end) begin
          state_next = S_INS_WR;
        end else begin
          ctl.up_step = 1'b1;
        end
      end
      S_INS_WR: begin
        ctl.ins_wr  = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.fin     = 1'b1;
        state_next  = S_IDLE;
      end
      S_SHDN: begin
        if (stat.dn_end) begin
          ctl.cnt_dec = 1'b1;
          ctl.fin     = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.dn_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cmd_r <= CMD_LOOKUP;
    end else begin
      state <= state_next;
      done  <= ctl.fin;
      if (ctl.load) begin
        cmd_r <= command;
      end
    end
  end

  // no word is taken while reset is held
  assign busy = rst || (state != S_IDLE);

endmodule

// ===== hdl/skvt_dpath.sv =====
module skvt_dpath #(
  parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH  = skvt_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = skvt_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  skvt_pkg::dp_cmd_t            ctl,
  input  logic [KEY_WIDTH-1:0]         key,
  input  logic [DATA_WIDTH-1:0]        value_in,
  output skvt_pkg::dp_stat_t           stat,
  output skvt_pkg::status_t            status,
  output logic [DATA_WIDTH-1:0]        value_out,
  output logic [$clog2(CAPACITY+1)-1:0] entry_total
);
  import skvt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0]  kmem [CAPACITY];
  logic [DATA_WIDTH-1:0] vmem [CAPACITY];

  logic [KEY_WIDTH-1:0]  key_r, rkey, wkey;
  logic [DATA_WIDTH-1:0] val_r, rval, wval;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      lo, hi, mid, mid_r, cur;
  logic [IDX_W-1:0]      raddr, waddr, pend_addr;
  logic                  pend_valid, we;

  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    raddr = '0;
    if (ctl.srch_rd) begin
      raddr = mid[IDX_W-1:0];
    end else if (ctl.probe) begin
      raddr = lo[IDX_W-1:0];
    end else if (ctl.up_step) begin
      raddr = IDX_W'(cur - CNT_W'(1));
    end else if (ctl.dn_step) begin
      raddr = IDX_W'(cur + CNT_W'(1));
    end
  end

  // new pair write and shift moves never fall in the same cycle
  always_comb begin
    we    = ctl.ins_wr | pend_valid;
    waddr = ctl.ins_wr ? lo[IDX_W-1:0] : pend_addr;
    wkey  = ctl.ins_wr ? key_r : rkey;
    wval  = ctl.ins_wr ? val_r : rval;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      kmem[waddr] <= wkey;
      vmem[waddr] <= wval;
    end
    rkey <= kmem[raddr];
    rval <= vmem[raddr];
  end

  always_comb begin
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      count      <= count_next;
      pend_valid <= ctl.up_step | ctl.dn_step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= key;
      val_r <= value_in;
      lo    <= '0;
      hi    <= count;
    end
    if (ctl.srch_rd) begin
      mid_r <= mid;
    end
    if (ctl.srch_cmp) begin
      if (rkey < key_r) begin
        lo <= mid_r + CNT_W'(1);
      end else begin
        hi <= mid_r;
      end
    end
    if (ctl.up_init) begin
      cur <= count;
    end else if (ctl.dn_init) begin
      cur <= lo;
    end else if (ctl.up_step) begin
      pend_addr <= cur[IDX_W-1:0];
      cur       <= cur - CNT_W'(1);
    end else if (ctl.dn_step) begin
      pend_addr <= cur[IDX_W-1:0];
      cur       <= cur + CNT_W'(1);
    end
    if (ctl.fin) begin
      status      <= ctl.fin_status;
      value_out   <= ctl.fin_value ? rval : '0;
      entry_total <= count_next;
    end
  end

  assign stat.srch_done = (lo == hi);
  assign stat.hit       = (lo < count) && (rkey == key_r);
  assign stat.full      = (count == CNT_W'(CAPACITY));
  assign stat.up_end    = (cur == lo);
  assign stat.dn_end    = !((cur + CNT_W'(1)) < count);

endmodule

// ===== hdl/sorted_key_value_table_unit.sv =====
// channel   signals                          direction  accepted when
// command   start command key value_in       in         start && !busy
// result    done status value_out entry_total out       done (one cycle)
//
// Search alternates a midpoint read and a compare per halving step, then reads
// the entry at the lower bound. Insert then moves each entry above the slot up
// one place and writes the pair; remove moves each entry above it down one place.
// The table memories have one write port, so moves go singly. Clear skips search.
// Synchronous reset empties the table; stored words are not cleared.
// Results cannot be held off; the next command may start in the done cycle.
module sorted_key_value_table_unit #(
  parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH  = skvt_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = skvt_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  skvt_pkg::cmd_t                command,
  input  logic [KEY_WIDTH-1:0]          key,
  input  logic [DATA_WIDTH-1:0]         value_in,
  output logic                          done,
  output skvt_pkg::status_t             status,
  output logic [DATA_WIDTH-1:0]         value_out,
  output logic [$clog2(CAPACITY+1)-1:0] entry_total
);
  import skvt_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  skvt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  skvt_dpath #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .key         (key),
    .value_in    (value_in),
    .stat        (stat),
    .status      (status),
    .value_out   (value_out),
    .entry_total (entry_total)
  );

endmodule

// ===== sim/sorted_key_value_table_unit_tb.sv =====
module sorted_key_value_table_unit_tb;
  import skvt_pkg::*;

  localparam int SLOTS     = CAPACITY_DEF;
  localparam int POOL_SIZE = 96;
  localparam int N_PROBES  = 23;

  typedef struct packed {
    status_t     st;
    logic [31:0] val;
    logic [6:0]  cnt;
  } reply_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] k;
    logic [31:0] v;
    bit          typed;  // reply below is used as is
    reply_t      want;
  } probe_row_t;

  localparam reply_t ANY = '{ST_OK, 32'h0, 7'd0};

  // directed words: extremes, every command, both ends of the table
  localparam probe_row_t PROBES [N_PROBES] = '{
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}},
    '{CMD_REMOVE, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}},
    '{CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 7'd1}},
    '{CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd2}},
    '{CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1, '{ST_OK, 32'h0, 7'd3}},
    '{CMD_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b1, '{ST_OK, 32'h0, 7'd4}},
    '{CMD_INSERT, 32'h0000_0001, 32'h0000_0001, 1'b0, ANY},
    '{CMD_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 7'd5}},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd5}},
    '{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'hA5A5_A5A5, 7'd5}},
    '{CMD_LOOKUP, 32'h0000_0002, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd5}},
    // duplicate insert keeps the old data
    '{CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1, '{ST_PRESENT, 32'h0, 7'd5}},
    '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 7'd5}},
    '{CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd4}},
    '{CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd4}},
    '{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, ANY},
    '{CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd3}},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd2}},
    '{CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1, '{ST_OK, 32'h1, 7'd2}},
    '{CMD_CLEAR,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 7'd0}},
    '{CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}},
    '{CMD_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd0}},
    '{CMD_INSERT, 32'h0000_0003, 32'hC3C3_3C3C, 1'b0, ANY}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  cmd_t              command = CMD_LOOKUP;
  logic [31:0]       key = '0;
  logic [31:0]       value_in = '0;
  logic              done;
  status_t           status;
  logic [31:0]       value_out;
  logic [6:0]        entry_total;

  // shadow of the table
  logic [31:0] tbl_keys [SLOTS];
  logic [31:0] tbl_vals [SLOTS];
  int          tbl_count;

  reply_t      table_replies [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          mismatches;
  int          burst_left;

  sorted_key_value_table_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .key         (key),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .entry_total (entry_total)
  );

  always #5 clk = ~clk;

  function automatic reply_t apply_command(cmd_t c, logic [31:0] k, logic [31:0] v);
    reply_t r;
    int     lo;
    int     hi;
    int     mid;
    int     i;
    bit     hit;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < tbl_count) && (tbl_keys[lo] == k);
    r.st  = ST_OK;
    r.val = '0;
    case (c)
      CMD_LOOKUP: begin
        if (hit) r.val = tbl_vals[lo];
        else r.st = ST_NOT_FOUND;
      end
      CMD_INSERT: begin
        if (hit) begin
          r.st = ST_PRESENT;
        end else if (tbl_count >= SLOTS) begin
          r.st = ST_FULL;
        end else begin
          for (i = tbl_count; i > lo; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_vals[i] = tbl_vals[i-1];
          end
          tbl_keys[lo] = k;
          tbl_vals[lo] = v;
          tbl_count++;
        end
      end
      CMD_REMOVE: begin
        if (!hit) begin
          r.st = ST_NOT_FOUND;
        end else begin
          for (i = lo; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i+1];
            tbl_vals[i] = tbl_vals[i+1];
          end
          tbl_count--;
        end
      end
      default: tbl_count = 0;
    endcase
    r.cnt = 7'(tbl_count);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (table_replies.size() == 0) begin
        flag_mismatch("result word with no command pending", 32'(status), 32'h0);
      end else begin
        want = table_replies.pop_front();
        if (status !== want.st) flag_mismatch("status", 32'(status), 32'(want.st));
        if (value_out !== want.val) flag_mismatch("value_out", value_out, want.val);
        if (entry_total !== want.cnt)
          flag_mismatch("entry_total", 32'(entry_total), 32'(want.cnt));
      end
    end
  end

  // Drives one command word and waits for it to be taken. A gap, when one
  // is due, comes before the word so start never toggles within one step.
  task automatic send_word(input cmd_t c, input logic [31:0] k, input logic [31:0] v,
                           input bit typed = 1'b0, input reply_t typed_reply = ANY);
    reply_t r;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = $urandom_range(40, 1);
    end
    start    <= 1'b1;
    command  <= c;
    key      <= k;
    value_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_command(c, k, v);
    table_replies.push_back(typed ? typed_reply : r);
    burst_left--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 80) return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
    if (sel < 88) begin
      case ($urandom_range(3, 0))
        0: return 32'h0;
        1: return 32'hFFFF_FFFF;
        2: return 32'h1 << $urandom_range(31, 0);
        default: return ~(32'h1 << $urandom_range(31, 0));
      endcase
    end
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd(int ins_w, int rem_w, int clr_w);
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < clr_w) return CMD_CLEAR;
    if (sel < clr_w + ins_w) return CMD_INSERT;
    if (sel < clr_w + ins_w + rem_w) return CMD_REMOVE;
    return CMD_LOOKUP;
  endfunction

  task automatic run_mix(int n, int ins_w, int rem_w, int clr_w);
    repeat (n) send_word(pick_cmd(ins_w, rem_w, clr_w), pick_key(), $urandom);
  endtask

  initial begin
    int i;
    mismatches = 0;
    tbl_count  = 0;
    burst_left = $urandom_range(40, 1);
    for (i = 0; i < POOL_SIZE; i++)
      key_pool[i] = (i < 16) ? 32'($urandom_range(40, 0)) : $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_PROBES; i++)
      send_word(PROBES[i].cmd, PROBES[i].k, PROBES[i].v, PROBES[i].typed, PROBES[i].want);

    run_mix(250, 45, 20, 1);
    wait_drained();

    // fill to capacity, then work against a full table
    send_word(CMD_CLEAR, $urandom, $urandom);
    while (tbl_count < SLOTS) send_word(CMD_INSERT, pick_key(), $urandom);
    run_mix(30, 60, 0, 0);
    run_mix(50, 50, 45, 0);
    wait_drained();

    run_mix(300, 30, 35, 2);
    wait_drained();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && table_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
